[sv/assert_macros.svh]
// Assertion macros for the RTL of the grid walker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define CHK_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define CHK_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/drgw_pkg.sv]
package drgw_pkg;

  localparam int MAP_DIM    = 64;
  localparam int COORD_W    = $clog2(MAP_DIM);
  localparam int POS_W      = COORD_W + 2;
  localparam int ADDR_W     = 2 * COORD_W;
  localparam int MAP_CELLS  = MAP_DIM * MAP_DIM;
  localparam int DIST_W     = 32;
  localparam int STEP_LIMIT = 2 * MAP_DIM;
  localparam int CNT_W      = $clog2(STEP_LIMIT + 1);

  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_CAST = 1'b1;

  localparam logic ST_HIT     = 1'b0;
  localparam logic ST_ESCAPED = 1'b1;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_WALK
  } state_t;

  typedef struct packed {
    logic clear;
    logic load_wr;
    logic cast_start;
    logic step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic walk_done;
  } stat_t;

endpackage

[sv/dda_ray_grid_walk_core.sv]
// Grid ray walker over a 64 by 64 one-bit wall map.
// The input channel carries two kinds of request. A load writes one map cell
// and completes in the cycle of its transfer, with no result. A cast gives a
// start cell, steps and Q16.16 side and delta distances; it walks the map one
// cell per clock and yields one result on the output channel.
// A cast walks 1 to 128 steps. Once the walk ends and the output register is
// free, the result is registered: out_valid rises in the same cycle as the
// input is freed. The walk loop performs one distance compare, one saturating
// add and one map read per clock.
// The block takes one request at a time: the next request is accepted in the
// cycle after the result has been registered, while that result may still be
// waiting on the output.
// If the receiver stalls while a result is held, a finished walk waits until
// the output register is free; the held result does not change.
// After reset the map is cleared to open one cell per clock; in_stall stays
// high throughout.
module dda_ray_grid_walk_core (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          in_req_type,
  input  logic [drgw_pkg::COORD_W-1:0]  in_cell_x,
  input  logic [drgw_pkg::COORD_W-1:0]  in_cell_y,
  input  logic                          in_cell_wall,
  input  logic signed [1:0]             in_step_x,
  input  logic signed [1:0]             in_step_y,
  input  logic [drgw_pkg::DIST_W-1:0]   in_side_dist_x,
  input  logic [drgw_pkg::DIST_W-1:0]   in_side_dist_y,
  input  logic [drgw_pkg::DIST_W-1:0]   in_delta_dist_x,
  input  logic [drgw_pkg::DIST_W-1:0]   in_delta_dist_y,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [drgw_pkg::DIST_W-1:0]   out_perp_dist,
  output logic                          out_hit_side,
  output logic [drgw_pkg::COORD_W-1:0]  out_hit_x,
  output logic [drgw_pkg::COORD_W-1:0]  out_hit_y,
  output logic                          out_status
);

  drgw_pkg::cmd_t  cmd;
  drgw_pkg::stat_t stat;

  drgw_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_req_type (in_req_type),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .stat        (stat),
    .cmd         (cmd)
  );

  drgw_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .stat            (stat),
    .in_cell_x       (in_cell_x),
    .in_cell_y       (in_cell_y),
    .in_cell_wall    (in_cell_wall),
    .in_step_x       (in_step_x),
    .in_step_y       (in_step_y),
    .in_side_dist_x  (in_side_dist_x),
    .in_side_dist_y  (in_side_dist_y),
    .in_delta_dist_x (in_delta_dist_x),
    .in_delta_dist_y (in_delta_dist_y),
    .out_perp_dist   (out_perp_dist),
    .out_hit_side    (out_hit_side),
    .out_hit_x       (out_hit_x),
    .out_hit_y       (out_hit_y),
    .out_status      (out_status)
  );

endmodule

[sv/drgw_ctrl.sv]
`include "assert_macros.svh"

module drgw_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  logic           in_req_type,
  output logic           out_valid,
  input  logic           out_stall,
  input  drgw_pkg::stat_t stat,
  output drgw_pkg::cmd_t  cmd
);

  drgw_pkg::state_t state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= drgw_pkg::S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_stall  = 1'b1;
    case (state_r)
      drgw_pkg::S_CLEAR: begin
        cmd.clear = 1'b1;
        if (stat.clear_last) begin
          state_nxt = drgw_pkg::S_IDLE;
        end
      end
      drgw_pkg::S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          if (in_req_type == drgw_pkg::REQ_CAST) begin
            cmd.cast_start = 1'b1;
            state_nxt      = drgw_pkg::S_WALK;
          end else begin
            cmd.load_wr = 1'b1;
          end
        end
      end
      drgw_pkg::S_WALK: begin
        if (!stat.walk_done) begin
          cmd.step = 1'b1;
        end else if (!out_valid_r || !out_stall) begin
          cmd.out_load = 1'b1;
          state_nxt    = drgw_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = drgw_pkg::S_CLEAR;
      end
    endcase
    out_valid_nxt = cmd.out_load | (out_valid_r & out_stall);
  end

  assign out_valid = out_valid_r;

  `CHK_ASSERT(a_out_slot_free, clk, rst_n, cmd.out_load |-> (!out_valid_r || !out_stall), "result register overwritten while stalled")
  `CHK_ASSERT(a_cast_enters_walk, clk, rst_n, (state_r == drgw_pkg::S_IDLE && in_valid && in_req_type == drgw_pkg::REQ_CAST) |=> (state_r == drgw_pkg::S_WALK), "accepted cast did not start a walk")
  `CHK_ASSERT(a_one_command, clk, rst_n, $onehot0({cmd.clear, cmd.load_wr, cmd.cast_start, cmd.step, cmd.out_load}), "more than one datapath command at once")
  `CHK_ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> (state_r == drgw_pkg::S_CLEAR && !out_valid_r), "reset did not start the clearing pass")

endmodule

[sv/drgw_dp.sv]
module drgw_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  drgw_pkg::cmd_t                cmd,
  output drgw_pkg::stat_t               stat,
  input  logic [drgw_pkg::COORD_W-1:0]  in_cell_x,
  input  logic [drgw_pkg::COORD_W-1:0]  in_cell_y,
  input  logic                          in_cell_wall,
  input  logic signed [1:0]             in_step_x,
  input  logic signed [1:0]             in_step_y,
  input  logic [drgw_pkg::DIST_W-1:0]   in_side_dist_x,
  input  logic [drgw_pkg::DIST_W-1:0]   in_side_dist_y,
  input  logic [drgw_pkg::DIST_W-1:0]   in_delta_dist_x,
  input  logic [drgw_pkg::DIST_W-1:0]   in_delta_dist_y,
  output logic [drgw_pkg::DIST_W-1:0]   out_perp_dist,
  output logic                          out_hit_side,
  output logic [drgw_pkg::COORD_W-1:0]  out_hit_x,
  output logic [drgw_pkg::COORD_W-1:0]  out_hit_y,
  output logic                          out_status
);

  logic                          map_mem [drgw_pkg::MAP_CELLS];
  logic                          rd_wall_r;
  logic [drgw_pkg::ADDR_W-1:0]   clr_addr_r, clr_addr_nxt;
  logic [drgw_pkg::POS_W-1:0]    pos_x_r, pos_x_nxt, pos_y_r, pos_y_nxt;
  logic [drgw_pkg::DIST_W-1:0]   acc_x_r, acc_x_nxt, acc_y_r, acc_y_nxt;
  logic [drgw_pkg::DIST_W-1:0]   dlt_x_r, dlt_x_nxt, dlt_y_r, dlt_y_nxt;
  logic [1:0]                    stp_x_r, stp_x_nxt, stp_y_r, stp_y_nxt;
  logic                          side_r, side_nxt;
  logic                          first_r, first_nxt;
  logic [drgw_pkg::CNT_W-1:0]    cnt_r, cnt_nxt;
  logic [drgw_pkg::DIST_W-1:0]   perp_r, perp_nxt;
  logic                          hside_r, hside_nxt;
  logic [drgw_pkg::COORD_W-1:0]  hx_r, hx_nxt, hy_r, hy_nxt;
  logic                          status_r, status_nxt;

  logic [drgw_pkg::DIST_W:0]     sum_x, sum_y;
  logic [drgw_pkg::DIST_W-1:0]   sat_x, sat_y;
  logic [drgw_pkg::POS_W-1:0]    pos_x_stp, pos_y_stp;
  logic                          x_lt, in_map, hit;
  logic                          wr_en, wr_data;
  logic [drgw_pkg::ADDR_W-1:0]   wr_addr, rd_addr;

  assign x_lt  = acc_x_r < acc_y_r;
  assign sum_x = {1'b0, acc_x_r} + {1'b0, dlt_x_r};
  assign sum_y = {1'b0, acc_y_r} + {1'b0, dlt_y_r};
  assign sat_x = sum_x[drgw_pkg::DIST_W] ? '1 : sum_x[drgw_pkg::DIST_W-1:0];
  assign sat_y = sum_y[drgw_pkg::DIST_W] ? '1 : sum_y[drgw_pkg::DIST_W-1:0];
  assign pos_x_stp = pos_x_r + {{(drgw_pkg::POS_W-2){stp_x_r[1]}}, stp_x_r};
  assign pos_y_stp = pos_y_r + {{(drgw_pkg::POS_W-2){stp_y_r[1]}}, stp_y_r};

  assign in_map = (pos_x_r[drgw_pkg::POS_W-1:drgw_pkg::COORD_W] == '0) &&
                  (pos_y_r[drgw_pkg::POS_W-1:drgw_pkg::COORD_W] == '0);
  assign hit    = in_map && rd_wall_r;

  assign stat.walk_done  = !first_r && (!in_map || rd_wall_r ||
                           cnt_r == drgw_pkg::CNT_W'(drgw_pkg::STEP_LIMIT));
  assign stat.clear_last = (clr_addr_r == '1);

  always_comb begin
    pos_x_nxt    = pos_x_r;
    pos_y_nxt    = pos_y_r;
    acc_x_nxt    = acc_x_r;
    acc_y_nxt    = acc_y_r;
    dlt_x_nxt    = dlt_x_r;
    dlt_y_nxt    = dlt_y_r;
    stp_x_nxt    = stp_x_r;
    stp_y_nxt    = stp_y_r;
    side_nxt     = side_r;
    first_nxt    = first_r;
    cnt_nxt      = cnt_r;
    clr_addr_nxt = clr_addr_r;
    perp_nxt     = perp_r;
    hside_nxt    = hside_r;
    hx_nxt       = hx_r;
    hy_nxt       = hy_r;
    status_nxt   = status_r;
    if (cmd.clear) begin
      clr_addr_nxt = clr_addr_r + 1'b1;
    end
    if (cmd.cast_start) begin
      pos_x_nxt = {2'b00, in_cell_x};
      pos_y_nxt = {2'b00, in_cell_y};
      acc_x_nxt = in_side_dist_x;
      acc_y_nxt = in_side_dist_y;
      dlt_x_nxt = in_delta_dist_x;
      dlt_y_nxt = in_delta_dist_y;
      stp_x_nxt = in_step_x;
      stp_y_nxt = in_step_y;
      side_nxt  = 1'b0;
      first_nxt = 1'b1;
      cnt_nxt   = '0;
    end
    if (cmd.step) begin
      first_nxt = 1'b0;
      cnt_nxt   = cnt_r + 1'b1;
      if (x_lt) begin
        acc_x_nxt = sat_x;
        pos_x_nxt = pos_x_stp;
        side_nxt  = 1'b0;
      end else begin
        acc_y_nxt = sat_y;
        pos_y_nxt = pos_y_stp;
        side_nxt  = 1'b1;
      end
    end
    if (cmd.out_load) begin
      perp_nxt   = side_r ? (acc_y_r - dlt_y_r) : (acc_x_r - dlt_x_r);
      hside_nxt  = side_r;
      hx_nxt     = hit ? pos_x_r[drgw_pkg::COORD_W-1:0] : '0;
      hy_nxt     = hit ? pos_y_r[drgw_pkg::COORD_W-1:0] : '0;
      status_nxt = hit ? drgw_pkg::ST_HIT : drgw_pkg::ST_ESCAPED;
    end
  end

  assign wr_en   = cmd.clear | cmd.load_wr;
  assign wr_addr = cmd.clear ? clr_addr_r : {in_cell_y, in_cell_x};
  assign wr_data = cmd.clear ? 1'b0 : in_cell_wall;
  assign rd_addr = {pos_y_nxt[drgw_pkg::COORD_W-1:0], pos_x_nxt[drgw_pkg::COORD_W-1:0]};

  always_ff @(posedge clk) begin
    if (wr_en) begin
      map_mem[wr_addr] <= wr_data;
    end
    rd_wall_r <= map_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_addr_r <= '0;
      first_r    <= 1'b0;
      cnt_r      <= '0;
    end else begin
      clr_addr_r <= clr_addr_nxt;
      first_r    <= first_nxt;
      cnt_r      <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pos_x_r  <= pos_x_nxt;
    pos_y_r  <= pos_y_nxt;
    acc_x_r  <= acc_x_nxt;
    acc_y_r  <= acc_y_nxt;
    dlt_x_r  <= dlt_x_nxt;
    dlt_y_r  <= dlt_y_nxt;
    stp_x_r  <= stp_x_nxt;
    stp_y_r  <= stp_y_nxt;
    side_r   <= side_nxt;
    perp_r   <= perp_nxt;
    hside_r  <= hside_nxt;
    hx_r     <= hx_nxt;
    hy_r     <= hy_nxt;
    status_r <= status_nxt;
  end

  assign out_perp_dist = perp_r;
  assign out_hit_side  = hside_r;
  assign out_hit_x     = hx_r;
  assign out_hit_y     = hy_r;
  assign out_status    = status_r;

endmodule

[tb/sv/dda_ray_grid_walk_core_tb.sv]
module dda_ray_grid_walk_core_tb;
  import drgw_pkg::*;

  localparam logic [DIST_W-1:0] ONE  = 32'h0001_0000;
  localparam logic [DIST_W-1:0] DMAX = 32'hFFFF_FFFF;
  localparam logic SIDE_X = 1'b0;
  localparam logic SIDE_Y = 1'b1;
  localparam int LONG_HOLD = 300;
  localparam int RANDOM_ITEMS = 480;

  typedef struct packed {
    logic              req_type;
    logic [COORD_W-1:0] cx;
    logic [COORD_W-1:0] cy;
    logic              wall;
    logic [1:0]        sx;
    logic [1:0]        sy;
    logic [DIST_W-1:0] sdx;
    logic [DIST_W-1:0] sdy;
    logic [DIST_W-1:0] ddx;
    logic [DIST_W-1:0] ddy;
  } ray_req_t;

  typedef struct packed {
    logic [DIST_W-1:0]  perp;
    logic               side;
    logic [COORD_W-1:0] hx;
    logic [COORD_W-1:0] hy;
    logic               status;
  } ray_hit_t;

  typedef struct packed {
    ray_req_t req;
    logic     typed;
    ray_hit_t res;
  } script_row_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_req_type;
  logic [COORD_W-1:0] in_cell_x;
  logic [COORD_W-1:0] in_cell_y;
  logic in_cell_wall;
  logic signed [1:0] in_step_x;
  logic signed [1:0] in_step_y;
  logic [DIST_W-1:0] in_side_dist_x;
  logic [DIST_W-1:0] in_side_dist_y;
  logic [DIST_W-1:0] in_delta_dist_x;
  logic [DIST_W-1:0] in_delta_dist_y;
  logic out_valid;
  logic out_stall;
  logic [DIST_W-1:0] out_perp_dist;
  logic out_hit_side;
  logic [COORD_W-1:0] out_hit_x;
  logic [COORD_W-1:0] out_hit_y;
  logic out_status;

  bit wall_bits [MAP_DIM][MAP_DIM];
  ray_hit_t pending_hits[$];
  script_row_t script[$];
  int unsigned fault_count;
  int unsigned results_seen;
  bit no_idle;
  bit hold_off_req;

  dda_ray_grid_walk_core DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_req_type    (in_req_type),
    .in_cell_x      (in_cell_x),
    .in_cell_y      (in_cell_y),
    .in_cell_wall   (in_cell_wall),
    .in_step_x      (in_step_x),
    .in_step_y      (in_step_y),
    .in_side_dist_x (in_side_dist_x),
    .in_side_dist_y (in_side_dist_y),
    .in_delta_dist_x(in_delta_dist_x),
    .in_delta_dist_y(in_delta_dist_y),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_perp_dist  (out_perp_dist),
    .out_hit_side   (out_hit_side),
    .out_hit_x      (out_hit_x),
    .out_hit_y      (out_hit_y),
    .out_status     (out_status)
  );

  initial clk = 1'b0;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [DIST_W-1:0] dist_add(input logic [DIST_W-1:0] a,
                                                 input logic [DIST_W-1:0] b);
    logic [DIST_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[DIST_W] ? DMAX : s[DIST_W-1:0];
  endfunction

  function automatic ray_hit_t trace_ray(input ray_req_t r);
    ray_hit_t res;
    logic [DIST_W-1:0] ax, ay;
    int px, py, dxs, dys, n;
    bit hit, side_y;
    res = '0;
    ax = r.sdx;
    ay = r.sdy;
    px = int'(r.cx);
    py = int'(r.cy);
    dxs = int'($signed(r.sx));
    dys = int'($signed(r.sy));
    hit = 1'b0;
    side_y = 1'b0;
    for (n = 0; n < STEP_LIMIT; n++) begin
      if (ax < ay) begin
        ax = dist_add(ax, r.ddx);
        px += dxs;
        side_y = 1'b0;
      end else begin
        ay = dist_add(ay, r.ddy);
        py += dys;
        side_y = 1'b1;
      end
      if (px < 0 || px >= MAP_DIM || py < 0 || py >= MAP_DIM) break;
      if (wall_bits[py][px]) begin
        hit = 1'b1;
        break;
      end
    end
    res.perp = side_y ? ay - r.ddy : ax - r.ddx;
    res.side = side_y ? SIDE_Y : SIDE_X;
    res.status = hit ? ST_HIT : ST_ESCAPED;
    if (hit) begin
      res.hx = px[COORD_W-1:0];
      res.hy = py[COORD_W-1:0];
    end
    return res;
  endfunction

  function automatic ray_req_t mk_load(input int x, input int y, input logic w);
    ray_req_t r;
    r = '0;
    r.req_type = REQ_LOAD;
    r.cx = x[COORD_W-1:0];
    r.cy = y[COORD_W-1:0];
    r.wall = w;
    return r;
  endfunction

  function automatic ray_req_t mk_cast(input int x, input int y,
                                       input int sx, input int sy,
                                       input logic [DIST_W-1:0] sdx,
                                       input logic [DIST_W-1:0] sdy,
                                       input logic [DIST_W-1:0] ddx,
                                       input logic [DIST_W-1:0] ddy);
    ray_req_t r;
    r = '0;
    r.req_type = REQ_CAST;
    r.cx = x[COORD_W-1:0];
    r.cy = y[COORD_W-1:0];
    r.sx = sx[1:0];
    r.sy = sy[1:0];
    r.sdx = sdx;
    r.sdy = sdy;
    r.ddx = ddx;
    r.ddy = ddy;
    return r;
  endfunction

  function automatic script_row_t plain(input ray_req_t r);
    return '{r, 1'b0, ray_hit_t'('0)};
  endfunction

  function automatic script_row_t known(input ray_req_t r, input logic [DIST_W-1:0] perp,
                                        input logic side, input int hx, input int hy,
                                        input logic status);
    return '{r, 1'b1, '{perp, side, hx[COORD_W-1:0], hy[COORD_W-1:0], status}};
  endfunction

  function automatic logic [DIST_W-1:0] pick_delta();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'hFFFF_0000 | $urandom_range(0, 16'hFFFF);
      2: return $urandom_range(0, 255);
      default: return $urandom_range(32'h0000_4000, 32'h0010_0000);
    endcase
  endfunction

  function automatic logic [DIST_W-1:0] pick_side(input logic [DIST_W-1:0] delta);
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return DMAX;
      default: return $urandom_range(0, delta);
    endcase
  endfunction

  function automatic logic [1:0] pick_step();
    if ($urandom_range(0, 6) == 0) return 2'($urandom_range(0, 3));
    return $urandom_range(0, 1) ? 2'b01 : 2'b11;
  endfunction

  task automatic offer(input ray_req_t r, input logic typed, input ray_hit_t res);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap > 0) begin
      @(negedge clk) in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_req_type     <= r.req_type;
    in_cell_x       <= r.cx;
    in_cell_y       <= r.cy;
    in_cell_wall    <= r.wall;
    in_step_x       <= r.sx;
    in_step_y       <= r.sy;
    in_side_dist_x  <= r.sdx;
    in_side_dist_y  <= r.sdy;
    in_delta_dist_x <= r.ddx;
    in_delta_dist_y <= r.ddy;
    in_valid        <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (r.req_type == REQ_LOAD) begin
      wall_bits[r.cy][r.cx] = r.wall;
    end else begin
      pending_hits.push_back(typed ? res : trace_ray(r));
    end
  endtask

  initial begin : result_sink
    int unsigned hold;
    forever begin
      hold = no_idle ? 0 : $urandom_range(0, 10);
      if (hold_off_req) begin
        hold = LONG_HOLD;
        hold_off_req = 1'b0;
      end
      if (hold > 0) begin
        @(negedge clk) out_stall <= 1'b1;
        repeat (hold - 1) @(negedge clk);
      end
      @(negedge clk) out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  always @(posedge clk) begin : result_check
    ray_hit_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_hits.size() == 0) begin
        if (fault_count < 10) begin
          $display("unexpected result %0d: perp %h side %0d x %0d y %0d status %0d",
                   results_seen, out_perp_dist, out_hit_side, out_hit_x, out_hit_y,
                   out_status);
        end
        fault_count++;
      end else begin
        want = pending_hits.pop_front();
        if (out_perp_dist !== want.perp || out_hit_side !== want.side ||
            out_hit_x !== want.hx || out_hit_y !== want.hy ||
            out_status !== want.status) begin
          if (fault_count < 10) begin
            $display("result %0d (expected/actual): perp %h/%h side %0d/%0d",
                     results_seen, want.perp, out_perp_dist, want.side, out_hit_side);
            $display("  hit x %0d/%0d hit y %0d/%0d status %0d/%0d",
                     want.hx, out_hit_x, want.hy, out_hit_y, want.status, out_status);
          end
          fault_count++;
        end
      end
    end
  end

  initial begin
    #6_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    ray_req_t r;
    logic [DIST_W-1:0] ddx, ddy;
    int lx, ly, drain;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_req_type = REQ_LOAD;
    in_cell_x = '0;
    in_cell_y = '0;
    in_cell_wall = 1'b0;
    in_step_x = '0;
    in_step_y = '0;
    in_side_dist_x = '0;
    in_side_dist_y = '0;
    in_delta_dist_x = '0;
    in_delta_dist_y = '0;
    out_stall = 1'b1;
    fault_count = 0;
    results_seen = 0;
    no_idle = 1'b0;
    hold_off_req = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    script.push_back(known(mk_cast(0, 0, -1, -1, 0, 0, ONE, ONE),
                           0, SIDE_Y, 0, 0, ST_ESCAPED));
    script.push_back(known(mk_cast(63, 63, 1, 1, 0, 1, ONE, ONE),
                           0, SIDE_X, 0, 0, ST_ESCAPED));
    script.push_back(plain(mk_load(5, 0, 1'b1)));
    script.push_back(known(mk_cast(0, 0, 1, 1, 0, DMAX, ONE, ONE),
                           32'h0004_0000, SIDE_X, 5, 0, ST_HIT));
    script.push_back(plain(mk_load(0, 0, 1'b1)));
    script.push_back(known(mk_cast(0, 1, -1, -1, DMAX, 0, ONE, 32'h1234_5678),
                           0, SIDE_Y, 0, 0, ST_HIT));
    script.push_back(plain(mk_load(20, 20, 1'b1)));
    script.push_back(plain(mk_cast(20, 20, 1, 1, 32'h8000, 32'hC000, ONE, ONE)));
    script.push_back(plain(mk_cast(10, 10, 0, 0, 0, 0, 1, 1)));
    script.push_back(plain(mk_cast(9, 9, -2, 1, 32'h8000, 32'h1_8000, ONE, 2 * ONE)));
    script.push_back(plain(mk_cast(30, 30, 1, -1, DMAX, DMAX, DMAX, DMAX)));
    script.push_back(plain(mk_cast(32, 40, 1, 1, 32'hFFFF_0000, DMAX, 32'h2_0000, 0)));
    script.push_back(plain(mk_load(63, 63, 1'b1)));
    script.push_back(plain(mk_cast(63, 60, 0, 1, 32'h100, 32'h3_0000, 32'h4000, ONE)));
    script.push_back(plain(mk_load(5, 0, 1'b0)));
    script.push_back(plain(mk_cast(0, 0, 1, 1, 0, DMAX, ONE, ONE)));
    script.push_back(plain(mk_cast(32, 32, 1, 1, 0, 0, 0, 0)));
    script.push_back(plain(mk_load(63, 0, 1'b0)));
    script.push_back(plain(mk_cast(0, 63, 1, -1, ONE, 32'h7FFF, 32'h1_6A09, ONE)));
    script.push_back(plain(mk_load(31, 40, 1'b1)));
    script.push_back(plain(mk_cast(31, 31, -1, 1, DMAX, 0, ONE, ONE)));
    script.push_back(plain(mk_cast(63, 0, -1, 1, 32'h1_0000, 32'h0_8000, DMAX, 32'h1)));

    foreach (script[i]) offer(script[i].req, script[i].typed, script[i].res);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 40 == 0) no_idle = ($urandom_range(0, 3) == 0);
      if (i == 60) hold_off_req = 1'b1;
      if ($urandom_range(0, 99) < 35) begin
        lx = $urandom_range(0, 63);
        ly = $urandom_range(0, 63);
        case ($urandom_range(0, 3))
          0: lx = 8 + 16 * $urandom_range(0, 3);
          1: ly = 8 + 16 * $urandom_range(0, 3);
          default: ;
        endcase
        r = mk_load(lx, ly, $urandom_range(0, 9) < 8);
      end else begin
        ddx = pick_delta();
        ddy = pick_delta();
        r = mk_cast($urandom_range(0, 63), $urandom_range(0, 63), pick_step(), pick_step(),
                    pick_side(ddx), pick_side(ddy), ddx, ddy);
        r.wall = 1'($urandom_range(0, 1));
      end
      offer(r, 1'b0, ray_hit_t'('0));
    end

    @(negedge clk) in_valid <= 1'b0;
    drain = 0;
    while (pending_hits.size() != 0 && drain < 20000) begin
      @(posedge clk);
      drain++;
    end
    repeat (150) @(posedge clk);
    if (pending_hits.size() != 0) begin
      $display("%0d expected results never arrived", pending_hits.size());
      fault_count += pending_hits.size();
    end
    if (fault_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
